// ===== src/hmt_pkg.sv =====
// ----------------------------------------------------------------------------
// hmt_pkg: shared types and constants for the homogeneous transform block
// Word widths, status codes, pipeline latencies and the divider result type.
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_COMP  = 4;

  // Latency of the matrix stage and of one divider, in register stages
  localparam int unsigned XF_LAT  = 3;
  localparam int unsigned DIV_LAT = DATA_W + 2;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CFG_W-1:0]         cfg_word_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_W_ZERO = 2'd1,
    STAT_Z_ZERO = 2'd2,
    STAT_SAT    = 2'd3
  } status_e;

  typedef struct packed {
    word_t quot;
    logic  sat;
  } div_res_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ===== src/homogeneous_transform_project_top.sv =====
// ----------------------------------------------------------------------------
// homogeneous_transform_project_top: 4x4 transform with perspective divide
// Multiplies a point by the configured matrix, divides by the fourth
// component and projects onto the image plane.
// ----------------------------------------------------------------------------
// Takes one point word per cycle and returns one result word per cycle while
// the output is not stalled. A word passes 3 stages of matrix multiply and
// sum, two chained 34-stage dividers (one quotient bit per stage, 32 bits
// each), and the output register, 72 registers in all with the first one
// loaded at the accepting edge. A stall on the output halts the pipeline only
// when its last stage holds a word; bubbles keep draining and the input keeps
// being taken until then. Matrix writes take effect on the next accepted word
// and must be made while the pipeline is empty.
module homogeneous_transform_project_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hmt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  hmt_pkg::cfg_word_t          cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  hmt_pkg::word_t              obj_x_i,
  input  hmt_pkg::word_t              obj_y_i,
  input  hmt_pkg::word_t              obj_z_i,
  input  hmt_pkg::word_t              obj_w_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output hmt_pkg::word_t              cam_x_o,
  output hmt_pkg::word_t              cam_y_o,
  output hmt_pkg::word_t              cam_z_o,
  output hmt_pkg::word_t              img_x_o,
  output hmt_pkg::word_t              img_y_o,
  output logic [1:0]                  status_o
);
  import hmt_pkg::*;

  localparam int unsigned LAT  = XF_LAT + 2 * DIV_LAT;
  localparam int unsigned D2_W = 3 * DATA_W + 3;
  localparam cfg_word_t ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam cfg_word_t ONE_HI = ONE_LO << DATA_W;

  // identity matrix word for a register index
  function automatic cfg_word_t reg_reset(logic [CFG_IDX_W-1:0] idx);
    cfg_word_t val;
    val = '0;
    if (idx[2] == idx[0]) begin
      val = idx[1] ? ONE_HI : ONE_LO;
    end
    return val;
  endfunction

  cfg_word_t m_q [NUM_REGS];

  // matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        m_q[i] <= reg_reset(CFG_IDX_W'(i));
      end
    end else if (cfg_we_i) begin
      m_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // pipeline flow control
  logic           adv;
  logic [LAT-1:0] v_q;
  logic           out_valid_q;

  assign adv        = !(out_valid_q && out_stall_i && v_q[LAT-1]);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v_q <= {v_q[LAT-2:0], in_valid_i};
      end
      if (adv && v_q[LAT-1]) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // matrix multiply
  word_t p   [NUM_COMP];
  word_t t   [NUM_COMP];
  logic  sat_t;
  logic  wz_t;

  assign p[0] = obj_x_i;
  assign p[1] = obj_y_i;
  assign p[2] = obj_z_i;
  assign p[3] = obj_w_i;

  hmt_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk_i   (clk_i),
    .en_i    (adv),
    .m_i     (m_q),
    .p_i     (p),
    .t_o     (t),
    .sat_o   (sat_t),
    .wzero_o (wz_t)
  );

  // divide by the fourth component
  div_res_t cam [3];
  for (genvar k = 0; k < 3; k++) begin : g_cam
    hmt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (t[k]),
      .den_i (t[NUM_COMP-1]),
      .res_o (cam[k])
    );
  end

  logic [1:0] d1_q;
  hmt_delay #(.WIDTH(2), .DEPTH(DIV_LAT)) u_dly1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({sat_t, wz_t}),
    .q_o   (d1_q)
  );

  // perspective divide by depth
  logic     sat_c;
  logic     zz_c;
  div_res_t img [2];

  assign sat_c = d1_q[1] || cam[0].sat || cam[1].sat || cam[2].sat;
  assign zz_c  = (cam[2].quot == '0);

  for (genvar k = 0; k < 2; k++) begin : g_img
    hmt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (cam[k].quot),
      .den_i (cam[2].quot),
      .res_o (img[k])
    );
  end

  logic [D2_W-1:0] d2_q;
  hmt_delay #(.WIDTH(D2_W), .DEPTH(DIV_LAT)) u_dly2 (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({cam[0].quot, cam[1].quot, cam[2].quot, sat_c, d1_q[0], zz_c}),
    .q_o   (d2_q)
  );

  // resolve special cases and status
  word_t   cx_d, cy_d, cz_d, ix_d, iy_d;
  status_e st_d;
  word_t   cx_q, cy_q, cz_q, ix_q, iy_q;
  status_e st_q;

  always_comb begin
    cx_d = d2_q[D2_W-1 -: DATA_W];
    cy_d = d2_q[D2_W-1-DATA_W -: DATA_W];
    cz_d = d2_q[D2_W-1-2*DATA_W -: DATA_W];
    ix_d = img[0].quot;
    iy_d = img[1].quot;
    st_d = STAT_OK;
    if (d2_q[1]) begin
      cx_d = '0;
      cy_d = '0;
      cz_d = '0;
      ix_d = '0;
      iy_d = '0;
      st_d = STAT_W_ZERO;
    end else if (d2_q[0]) begin
      ix_d = '0;
      iy_d = '0;
      st_d = STAT_Z_ZERO;
    end else if (d2_q[2] || img[0].sat || img[1].sat) begin
      st_d = STAT_SAT;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv && v_q[LAT-1]) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
      ix_q <= ix_d;
      iy_q <= iy_d;
      st_q <= st_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cam_x_o     = cx_q;
  assign cam_y_o     = cy_q;
  assign cam_z_o     = cz_q;
  assign img_x_o     = ix_q;
  assign img_y_o     = iy_q;
  assign status_o    = st_q;

endmodule

// ===== src/hmt_xform.sv =====
// ----------------------------------------------------------------------------
// hmt_xform: 4x4 matrix times homogeneous point
// Stage 1 multiplies, stage 2 adds pairs, stage 3 adds, floors and saturates.
// ----------------------------------------------------------------------------
module hmt_xform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  hmt_pkg::cfg_word_t m_i [hmt_pkg::NUM_REGS],
  input  hmt_pkg::word_t    p_i [hmt_pkg::NUM_COMP],
  output hmt_pkg::word_t    t_o [hmt_pkg::NUM_COMP],
  output logic              sat_o,
  output logic              wzero_o
);
  import hmt_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic signed [PROD_W-1:0] prod_q [NUM_COMP][NUM_COMP];
  logic signed [PAIR_W-1:0] pair_q [NUM_COMP][2];
  word_t                    t_d    [NUM_COMP];
  logic  [NUM_COMP-1:0]     rsat;
  word_t                    t_q    [NUM_COMP];
  logic                     sat_q;
  logic                     wzero_q;

  for (genvar r = 0; r < NUM_COMP; r++) begin : g_row
    // multiply each matrix entry by its point component
    for (genvar c = 0; c < NUM_COMP; c++) begin : g_col
      localparam int unsigned RI = 2 * r + c / 2;
      word_t                    ent;
      logic signed [PROD_W-1:0] prod_d;
      if (c % 2 == 1) begin : g_hi
        assign ent = m_i[RI][2*DATA_W-1:DATA_W];
      end else begin : g_lo
        assign ent = m_i[RI][DATA_W-1:0];
      end
      assign prod_d = PROD_W'(ent) * PROD_W'(p_i[c]);
      always_ff @(posedge clk_i) begin
        if (en_i) prod_q[r][c] <= prod_d;
      end
    end

    // add products in pairs
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pair_q[r][0] <= PAIR_W'(prod_q[r][0]) + PAIR_W'(prod_q[r][1]);
        pair_q[r][1] <= PAIR_W'(prod_q[r][2]) + PAIR_W'(prod_q[r][3]);
      end
    end

    // final sum, floor to the fixed-point grid, clamp to one word
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sh;
    logic [SUM_W-DATA_W:0]    top;
    always_comb begin
      sum     = SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]);
      sh      = sum >>> FRAC_BITS;
      top     = sh[SUM_W-1:DATA_W-1];
      rsat[r] = !((&top) || !(|top));
      if (rsat[r]) begin
        t_d[r] = sh[SUM_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
        t_d[r] = sh[DATA_W-1:0];
      end
    end
  end

  // register transformed point and flags
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q     <= t_d;
      sat_q   <= |rsat;
      wzero_q <= (t_d[NUM_COMP-1] == '0);
    end
  end

  assign t_o     = t_q;
  assign sat_o   = sat_q;
  assign wzero_o = wzero_q;

endmodule

// ===== src/hmt_div.sv =====
// ----------------------------------------------------------------------------
// hmt_div: pipelined fixed-point divider
// Computes trunc(num * 2^FRAC_BITS / den) saturated to one word, one
// quotient bit per stage, restoring on magnitudes.
// ----------------------------------------------------------------------------
module hmt_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  hmt_pkg::word_t    num_i,
  input  hmt_pkg::word_t    den_i,
  output hmt_pkg::div_res_t res_o
);
  import hmt_pkg::*;

  localparam int unsigned NW   = DATA_W + FRAC_BITS;
  localparam int unsigned RQ_W = 2 * DATA_W;
  localparam logic [DATA_W-1:0] MIN_MAG = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] anum;
  logic [DATA_W-1:0] aden;
  logic [NW-1:0]     an;

  logic [RQ_W-1:0]   rq_q  [DATA_W+1];
  logic [DATA_W-1:0] ad_q  [DATA_W+1];
  logic              neg_q [DATA_W+1];
  logic              ovf_q [DATA_W+1];

  div_res_t          res_d;
  div_res_t          res_q;

  // take magnitudes and flag a quotient that cannot fit in one word
  always_comb begin
    anum = num_i[DATA_W-1] ? DATA_W'(-num_i) : DATA_W'(num_i);
    aden = den_i[DATA_W-1] ? DATA_W'(-den_i) : DATA_W'(den_i);
    an   = {anum, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rq_q[0]  <= RQ_W'(an);
      ad_q[0]  <= aden;
      neg_q[0] <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      ovf_q[0] <= (anum >> (DATA_W - FRAC_BITS)) >= aden;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < DATA_W; k++) begin : g_step
    logic [DATA_W:0]   cand;
    logic [DATA_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] rem;
    always_comb begin
      cand = rq_q[k][RQ_W-1:DATA_W-1];
      diff = cand - {1'b0, ad_q[k]};
      ge   = cand >= {1'b0, ad_q[k]};
      rem  = ge ? diff[DATA_W-1:0] : cand[DATA_W-1:0];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rq_q[k+1]  <= {rem, rq_q[k][DATA_W-2:0], ge};
        ad_q[k+1]  <= ad_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  // apply sign and clamp
  logic [DATA_W-1:0] q;
  always_comb begin
    q = rq_q[DATA_W][DATA_W-1:0];
    if (neg_q[DATA_W]) begin
      res_d.sat  = ovf_q[DATA_W] || (q > MIN_MAG);
      res_d.quot = res_d.sat ? WORD_MIN : word_t'(-q);
    end else begin
      res_d.sat  = ovf_q[DATA_W] || q[DATA_W-1];
      res_d.quot = res_d.sat ? WORD_MAX : word_t'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== src/hmt_delay.sv =====
// ----------------------------------------------------------------------------
// hmt_delay: enabled delay line
// Carries side data next to a divider so it arrives with the quotient.
// ----------------------------------------------------------------------------
module hmt_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  // advance the line
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// ===== src/hmt_checker.sv =====
// ----------------------------------------------------------------------------
// hmt_checker: port-level checks for the homogeneous transform block
// Checks that a stalled output word holds and that output words agree with the status code.
// ----------------------------------------------------------------------------
module hmt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input hmt_pkg::word_t cam_x_o,
  input hmt_pkg::word_t cam_y_o,
  input hmt_pkg::word_t cam_z_o,
  input hmt_pkg::word_t img_x_o,
  input hmt_pkg::word_t img_y_o,
  input logic [1:0]     status_o
);
  import hmt_pkg::*;

  // a stalled output word stays valid with cam_x and status unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cam_x_o) && $stable(status_o))
    else $error("stalled output word changed");

  // zero fourth component gives an all-zero word
  a_wzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_W_ZERO |->
      cam_x_o == '0 && cam_y_o == '0 && cam_z_o == '0 && img_x_o == '0 && img_y_o == '0)
    else $error("fourth-component-zero word has nonzero fields");

  // zero depth gives zero image coordinates
  a_zzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_Z_ZERO |->
      cam_z_o == '0 && img_x_o == '0 && img_y_o == '0)
    else $error("depth-zero word inconsistent");

  // a projected word has nonzero depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_OK || status_o == STAT_SAT) |-> cam_z_o != '0)
    else $error("projected word with zero depth");

endmodule

bind homogeneous_transform_project_top hmt_checker u_hmt_checker (.*);

// ===== tb/homogeneous_transform_project_top_tb.sv =====
// ----------------------------------------------------------------------------
// homogeneous_transform_project_top_tb: self-checking bench for the transform
// Drives homogeneous points through the 4x4 transform and perspective divide
// under several matrix settings and idle patterns, predicts each result word
// in fixed point and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module homogeneous_transform_project_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hmt_pkg::*;

  localparam int unsigned FRAC    = 16;
  localparam int unsigned LATENCY = 72;
  localparam int unsigned WDOG    = 20000;

  typedef struct packed {
    word_t   cx;
    word_t   cy;
    word_t   cz;
    word_t   ix;
    word_t   iy;
    status_e st;
  } proj_t;

  typedef enum int {
    MTX_R0_C01 = 0, MTX_R0_C23 = 1, MTX_R1_C01 = 2, MTX_R1_C23 = 3,
    MTX_R2_C01 = 4, MTX_R2_C23 = 5, MTX_R3_C01 = 6, MTX_R3_C23 = 7
  } mtx_reg_e;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  cfg_word_t cfg_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  word_t     obj_x_i, obj_y_i, obj_z_i, obj_w_i;
  logic      out_valid_o;
  logic      out_stall_i;
  word_t     cam_x_o, cam_y_o, cam_z_o, img_x_o, img_y_o;
  logic [1:0] status_o;

  cfg_word_t mtx_regs [NUM_REGS];
  proj_t     proj_q [$];
  int        mismatches;
  int        idle_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        timed_out;

  homogeneous_transform_project_top #(.FRAC_BITS(FRAC)) i_dut (.*);

  // Run the clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Saturate a wide value to one word
  function automatic longint clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Scaled divide toward zero, saturated
  function automatic longint frac_div(longint num, longint den, inout bit sat);
    longint n;
    n = num * (64'sd1 <<< FRAC);
    return clamp32(n / den, sat);
  endfunction

  // Predict one result word from a point and the current matrix
  function automatic proj_t project_point(word_t px, word_t py, word_t pz, word_t pw);
    proj_t         res;
    longint        p [4];
    longint        t [4];
    longint        cam [3];
    logic signed [79:0] acc;
    logic [31:0]   ent;
    bit            sat;
    sat = 1'b0;
    p[0] = px; p[1] = py; p[2] = pz; p[3] = pw;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        ent = (c % 2) ? mtx_regs[r*2 + c/2][63:32] : mtx_regs[r*2 + c/2][31:0];
        acc += 80'(longint'(signed'(ent)) * p[c]);
      end
      acc = acc >>> FRAC;
      if (acc > 80'sd2147483647) begin
        sat = 1'b1;
        t[r] = 64'sd2147483647;
      end else if (acc < -80'sd2147483648) begin
        sat = 1'b1;
        t[r] = -64'sd2147483648;
      end else begin
        t[r] = longint'(acc);
      end
    end
    res = '0;
    if (t[3] == 0) begin
      res.st = STAT_W_ZERO;
    end else begin
      for (int r = 0; r < 3; r++) cam[r] = frac_div(t[r], t[3], sat);
      res.cx = word_t'(cam[0]);
      res.cy = word_t'(cam[1]);
      res.cz = word_t'(cam[2]);
      if (cam[2] == 0) begin
        res.st = STAT_Z_ZERO;
      end else begin
        res.ix = word_t'(frac_div(cam[0], cam[2], sat));
        res.iy = word_t'(frac_div(cam[1], cam[2], sat));
        res.st = sat ? STAT_SAT : STAT_OK;
      end
    end
    return res;
  endfunction

  // Pick a point field: extremes, zero, small values, one, or full random
  function automatic word_t pick_coord();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3, 4: return word_t'($urandom_range(0, 8 << FRAC)) - word_t'(4 << FRAC);
      5: return word_t'(1 << FRAC);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_entry();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return 32'(1 << FRAC);
      4, 5: return 32'($urandom_range(0, 4 << FRAC)) - 32'(2 << FRAC);
      default: return $urandom;
    endcase
  endfunction

  // Write one matrix register; block must be idle
  task automatic write_reg(mtx_reg_e idx, cfg_word_t val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_W'(idx);
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    mtx_regs[idx] = val;
  endtask

  // Send one point word and queue its expected result
  task automatic send_point(word_t px, word_t py, word_t pz, word_t pw);
    @(negedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    obj_x_i <= px;
    obj_y_i <= py;
    obj_z_i <= pz;
    obj_w_i <= pw;
    do @(posedge clk_i); while (in_stall_o);
    proj_q.push_back(project_point(px, py, pz, pw));
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait for every expected word, then let the pipeline empty
  task automatic drain();
    end_burst();
    while (proj_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0)
        send_point(pick_coord(), pick_coord(), pick_coord(), word_t'(1 << FRAC));
      else
        send_point(pick_coord(), pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  task automatic load_random_matrix();
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(mtx_reg_e'(i), {pick_entry(), pick_entry()});
  endtask

  // Directed: identity matrix, extreme points, zero weight, zero depth
  task automatic test_directed();
    word_t one;
    one = word_t'(1 << FRAC);
    send_point(one, one, one, one);
    send_point(2 * one, -3 * one, 4 * one, one);
    send_point(one, one, one, '0);
    send_point(one, one, '0, one);
    send_point(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_point(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_point(WORD_MAX, WORD_MIN, one, 1);
    send_point(WORD_MIN, WORD_MAX, -one, -1);
    send_point(-one, 5 * one, 1, one);
    send_point(WORD_MAX, one, 2, one);
    send_point('1, '1, '1, '1);
    send_point(one, -one, 3 * one, -2 * one);
    drain();
  endtask

  // Extreme matrices: all max, all min, then zero row three
  task automatic test_extreme_matrix();
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(mtx_reg_e'(i), 64'h7FFF_FFFF_7FFF_FFFF);
    random_points(10);
    send_point(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    drain();
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(mtx_reg_e'(i), 64'h8000_0000_8000_0000);
    random_points(10);
    send_point(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    drain();
    write_reg(MTX_R3_C01, '0);
    write_reg(MTX_R3_C23, '0);
    random_points(5);
    drain();
  endtask

  // Random matrices under the given idle and stall pattern
  task automatic test_random(int sidle, int rstall, int n);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    for (int k = 0; k < 3; k++) begin
      load_random_matrix();
      random_points(n);
      drain();
    end
  endtask

  // Drive the receiver stall
  always @(negedge clk_i) begin
    if (!rst_ni)
      out_stall_i <= 1'b0;
    else
      out_stall_i <= recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct;
  end

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin
    proj_t exp_w;
    proj_t got_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_w = {cam_x_o, cam_y_o, cam_z_o, img_x_o, img_y_o, status_e'(status_o)};
      if (proj_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got_w);
      end else begin
        exp_w = proj_q.pop_front();
        if (exp_w !== got_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cam %0d %0d %0d img %0d %0d st %0d",
                     exp_w.cx, exp_w.cy, exp_w.cz, exp_w.ix, exp_w.iy, exp_w.st,
                     "\n          got cam %0d %0d %0d img %0d %0d st %0d",
                     got_w.cx, got_w.cy, got_w.cz, got_w.ix, got_w.iy, got_w.st);
        end
      end
    end
  end

  // Count cycles with no word moving on either side and no matrix write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WDOG);
    timed_out = 1'b1;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    obj_x_i = '0;
    obj_y_i = '0;
    obj_z_i = '0;
    obj_w_i = '0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    timed_out = 1'b0;
    mtx_regs[MTX_R0_C01] = 64'(1 << FRAC);
    mtx_regs[MTX_R0_C23] = '0;
    mtx_regs[MTX_R1_C01] = 64'(1 << FRAC) << 32;
    mtx_regs[MTX_R1_C23] = '0;
    mtx_regs[MTX_R2_C01] = '0;
    mtx_regs[MTX_R2_C23] = 64'(1 << FRAC);
    mtx_regs[MTX_R3_C01] = '0;
    mtx_regs[MTX_R3_C23] = 64'(1 << FRAC) << 32;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_extreme_matrix();
    test_random(0, 0, 110);
    test_random(61, 0, 110);
    test_random(0, 61, 110);
    test_random(21, 21, 110);

    if (mismatches == 0 && proj_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
